// ===== hdl/cts_pkg.sv =====
// Package with payload types, constants and calendar tables for the RTC snapshot converter.
package cts_pkg;

	// Payload of one input beat: the six raw RTC register bytes.
	typedef struct packed {
		logic [7:0] raw_seconds;
		logic [7:0] raw_minutes;
		logic [7:0] raw_hours;
		logic [7:0] raw_day;
		logic [7:0] raw_month;
		logic [7:0] raw_year;
	} cts_in_t;

	// Payload of one result beat.
	typedef struct packed {
		logic [31:0] unix_seconds;
		logic        fields_invalid;
	} cts_out_t;

	// Payload of one configuration write beat.
	typedef logic [7:0] cts_cfg_idx_t;

	typedef struct packed {
		cts_cfg_idx_t index;
		logic [7:0]   value;
	} cts_cfg_t;

	// Configuration register indexes.
	localparam cts_cfg_idx_t CFG_BINARY_MODE    = 8'd0;
	localparam cts_cfg_idx_t CFG_HOUR_FORMAT_24 = 8'd1;

	// Calendar constants.
	localparam logic [8:0]  YOE_BASE     = 9'd400;   // year of era of 2000 in the 1600 era
	localparam logic [18:0] DAYS_BIAS    = 19'd135080; // days from 1 March 1600 to the Unix epoch
	localparam logic [31:0] SECS_PER_DAY = 32'd86400;
	localparam logic [16:0] SECS_PER_HR  = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN = 17'd60;

	// Packed BCD byte to binary, without a digit check.
	function automatic logic [7:0] bcd_decode(input logic [7:0] v);
		bcd_decode = ({4'b0000, v[7:4]} * 8'd10) + {4'b0000, v[3:0]};
	endfunction

	// Length of a month 1..12; February is long in a leap year.
	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		case (mon)
			4'd2:    month_len = leap ? 5'd29 : 5'd28;
			4'd4:    month_len = 5'd30;
			4'd6:    month_len = 5'd30;
			4'd9:    month_len = 5'd30;
			4'd11:   month_len = 5'd30;
			default: month_len = 5'd31;
		endcase
	endfunction

	// Days from 1 March to the first day of a March-based month 0..11.
	function automatic logic [8:0] month_offset(input logic [3:0] mp);
		case (mp)
			4'd0:    month_offset = 9'd0;
			4'd1:    month_offset = 9'd31;
			4'd2:    month_offset = 9'd61;
			4'd3:    month_offset = 9'd92;
			4'd4:    month_offset = 9'd122;
			4'd5:    month_offset = 9'd153;
			4'd6:    month_offset = 9'd184;
			4'd7:    month_offset = 9'd214;
			4'd8:    month_offset = 9'd245;
			4'd9:    month_offset = 9'd275;
			4'd10:   month_offset = 9'd306;
			4'd11:   month_offset = 9'd337;
			default: month_offset = 9'd0;
		endcase
	endfunction

endpackage

// ===== hdl/cts_stream_if.sv =====
// Valid/ready channel interface carrying one payload per beat.
interface cts_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cmos_time_to_unix_seconds.sv =====
// Five-stage pipeline converting a raw RTC snapshot into Unix seconds.
// An accepted input beat moves through the stage registers s1 to s5 in order; its result is offered from s5.
// Throughput: one beat per cycle while the output is not stalled; every stage advances when the stage after it is free.
// A stall on the output holds every full stage with no empty stage after it, without loss or repetition.
// Reset clears all stage valid bits and sets both configuration registers to zero.
// Configuration writes are always accepted.
module cmos_time_to_unix_seconds (
	input  logic         clk,
	input  logic         arst_n,
	cts_stream_if.sink   cfg,
	cts_stream_if.sink   in,
	cts_stream_if.source out
);
	import cts_pkg::*;

	// Configuration registers.
	logic binary_mode_q;
	logic hour_format_24_q;

	// Stage valid bits and advance enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	// Stage payload registers.
	logic [5:0]  sec_s1, min_s1;
	logic [4:0]  hr_s1;
	logic [7:0]  day_s1, mon_s1, yr_s1;
	logic        bad_s1;

	logic [8:0]  yoe_s2, doy_s2;
	logic [16:0] sod_s2;
	logic        bad_s2;

	logic [15:0] days_s3;
	logic [16:0] sod_s3;
	logic        bad_s3;

	logic [31:0] tday_s4;
	logic [16:0] sod_s4;
	logic        bad_s4;

	logic [31:0] secs_s5;
	logic        bad_s5;

	// Configuration write port.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			binary_mode_q    <= 1'b0;
			hour_format_24_q <= 1'b0;
		end else if (cfg.valid) begin
			if (cfg.data.index == CFG_BINARY_MODE) begin
				binary_mode_q <= cfg.data.value[0];
			end else if (cfg.data.index == CFG_HOUR_FORMAT_24) begin
				hour_format_24_q <= cfg.data.value[0];
			end
		end
	end

	// A stage takes new data when it is empty or its contents move on.
	assign en5      = !v_s5 || out.ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// Stage 1: decode the bytes, convert the hour and check the time of day.
	logic [7:0] sec_d, min_d, hr_d, day_d, mon_d, yr_d, hr_bcd, hr_fin;
	logic [6:0] h7, hbase;
	logic       bad_h, bad_t;

	always_comb begin
		hr_bcd = bcd_decode({1'b0, in.data.raw_hours[6:0]});
		if (binary_mode_q) begin
			sec_d = in.data.raw_seconds;
			min_d = in.data.raw_minutes;
			hr_d  = in.data.raw_hours;
			day_d = in.data.raw_day;
			mon_d = in.data.raw_month;
			yr_d  = in.data.raw_year;
		end else begin
			sec_d = bcd_decode(in.data.raw_seconds);
			min_d = bcd_decode(in.data.raw_minutes);
			hr_d  = {in.data.raw_hours[7], hr_bcd[6:0]};
			day_d = bcd_decode(in.data.raw_day);
			mon_d = bcd_decode(in.data.raw_month);
			yr_d  = bcd_decode(in.data.raw_year);
		end

		// In 12-hour mode the clock hour must be 1..12; twelve is midnight or noon.
		h7    = hr_d[6:0];
		hbase = (h7 == 7'd12) ? 7'd0 : h7;
		if (hour_format_24_q) begin
			bad_h  = 1'b0;
			hr_fin = hr_d;
		end else begin
			bad_h  = (h7 == 7'd0) || (h7 > 7'd12);
			hr_fin = {1'b0, hbase} + (hr_d[7] ? 8'd12 : 8'd0);
		end

		bad_t = bad_h || (sec_d > 8'd59) || (min_d > 8'd59) || (hr_fin > 8'd23);
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sec_s1 <= sec_d[5:0];
			min_s1 <= min_d[5:0];
			hr_s1  <= hr_fin[4:0];
			day_s1 <= day_d;
			mon_s1 <= mon_d;
			yr_s1  <= yr_d;
			bad_s1 <= bad_t;
		end
	end

	// Stage 2: check the date, form the March-based year and day, and the second of day.
	logic       leq2, leap, bad_d;
	logic [3:0] mp;
	logic [4:0] lim;
	logic [8:0] yoe_n, doy_n;
	logic [16:0] sod_n;

	always_comb begin
		leap  = (yr_s1[1:0] == 2'b00);
		lim   = month_len(mon_s1[3:0], leap);
		bad_d = (yr_s1 > 8'd99) || (mon_s1 < 8'd1) || (mon_s1 > 8'd12)
			|| (day_s1 < 8'd1) || (day_s1 > {3'b000, lim});
		leq2  = (mon_s1 <= 8'd2);
		mp    = leq2 ? (mon_s1[3:0] + 4'd9) : (mon_s1[3:0] - 4'd3);
		yoe_n = YOE_BASE + {2'b00, yr_s1[6:0]} - {8'd0, leq2};
		doy_n = month_offset(mp) + {1'b0, day_s1} - 9'd1;
		sod_n = 17'({12'd0, hr_s1} * SECS_PER_HR) + 17'({11'd0, min_s1} * SECS_PER_MIN)
			+ {11'd0, sec_s1};
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			yoe_s2 <= yoe_n;
			doy_s2 <= doy_n;
			sod_s2 <= sod_n;
			bad_s2 <= bad_s1 || bad_d;
		end
	end

	// Stage 3: days since the epoch from the year of era and day of year.
	// Over years of era 399..499 the century terms, yoe/100 less yoe/400, come to three.
	logic [18:0] doe;

	always_comb begin
		doe = 19'({10'd0, yoe_s2} * 19'd365) + {12'd0, yoe_s2[8:2]} - 19'd3
			+ {10'd0, doy_s2};
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			days_s3 <= 16'(doe - DAYS_BIAS);
			sod_s3  <= sod_s2;
			bad_s3  <= bad_s2;
		end
	end

	// Stage 4: scale days to seconds.
	always_ff @(posedge clk) begin
		if (en4) begin
			tday_s4 <= 32'({16'd0, days_s3} * SECS_PER_DAY);
			sod_s4  <= sod_s3;
			bad_s4  <= bad_s3;
		end
	end

	// Stage 5: add the second of day, or give zero for an invalid snapshot.
	always_ff @(posedge clk) begin
		if (en5) begin
			secs_s5 <= bad_s4 ? 32'd0 : (tday_s4 + {15'd0, sod_s4});
			bad_s5  <= bad_s4;
		end
	end

	// Result beat.
	assign out.valid               = v_s5;
	assign out.data.unix_seconds   = secs_s5;
	assign out.data.fields_invalid = bad_s5;

endmodule
